// File: hdl/morph_pkg.sv
// Shared constants for the 3x3 erode/dilate stream filter.
// Holds port widths, parameter defaults and configuration register indexes.
// No dependencies.
package morph_pkg;

    localparam int IO_BITS         = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_IDX_BITS    = 3;
    localparam int IMG_W_BITS      = 12;
    localparam int IMG_H_BITS      = 16;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CHANNELS_DEF    = 3;

    localparam int WIDTH_RST       = 640;
    localparam int HEIGHT_RST      = 480;

    localparam logic ACT_PIXEL     = 1'b0;
    localparam logic ACT_DRAIN     = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DILATE = 3'd0,
        CFG_CROSS  = 3'd1,
        CFG_SIGNED = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } cfg_idx_t;

endpackage

// File: hdl/morph_erode_dilate_3x3.sv
// 3x3 grayscale erosion/dilation over a raster pixel stream, top level.
// Depends on morph_pkg. A request's results pass the stage B, stage C and output registers.
// Throughput: one request per cycle, drain or pixel, while the output takes results; a row's
//   last pixel below the top yields two (one at width one) via the single output register.
// Line history lives in one single-port-read line memory (registered read, write forwarding).
// Reset clears configuration, counters and pipeline valids; the line memory is not cleared.
module morph_erode_dilate_3x3 #(
    parameter int MAX_WIDTH   = morph_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = morph_pkg::SAMPLE_BITS_DEF,
    parameter int CHANNELS    = morph_pkg::CHANNELS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [morph_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [morph_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // input requests
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [morph_pkg::IO_BITS-1:0]        s_in_ch0,
    input  logic [morph_pkg::IO_BITS-1:0]        s_in_ch1,
    input  logic [morph_pkg::IO_BITS-1:0]        s_in_ch2,
    // result requests
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [morph_pkg::IO_BITS-1:0]        m_out_ch0,
    output logic [morph_pkg::IO_BITS-1:0]        m_out_ch1,
    output logic [morph_pkg::IO_BITS-1:0]        m_out_ch2,
    output logic                                 m_last_in_run,
    output logic                                 m_end_of_frame
);
    import morph_pkg::*;

    // Samples wider than the port carry only zeros above the port width.
    localparam int SW    = (SAMPLE_BITS < IO_BITS) ? SAMPLE_BITS : IO_BITS;
    localparam int HW    = CHANNELS * SW;
    localparam int MW    = 2 * HW;                 // {upper row, middle row}
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
    // Sign bit only exists up to the port width; wider samples ignore signed mode.
    localparam bit SIGN_VALID = (SAMPLE_BITS <= IO_BITS);

    // ------------------------------------------------------------------
    // Min/max selection with optional two's complement ordering.
    // ------------------------------------------------------------------
    function automatic logic [SW-1:0] pick2(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                            input logic dil, input logic sg);
        logic [SW-1:0] ka;
        logic [SW-1:0] kb;
        ka = {a[SW-1] ^ sg, a[SW-2:0]};
        kb = {b[SW-1] ^ sg, b[SW-2:0]};
        if (dil) begin
            return (ka >= kb) ? a : b;
        end
        return (ka <= kb) ? a : b;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    cfg_idx_t                cfg_sel;
    logic                    dilate_reg;
    logic                    cross_reg;
    logic                    signed_reg;
    logic                    sg;
    logic [CW-1:0]           eff_w_reg;
    logic [CW-1:0]           wm1_reg;
    logic [IMG_H_BITS-1:0]   eff_h_reg;
    logic [IMG_H_BITS-1:0]   hm1_reg;
    logic [IMG_W_BITS-1:0]   iw;
    logic [IMG_H_BITS-1:0]   ih;
    logic [CW-1:0]           cfg_w;
    logic [IMG_H_BITS-1:0]   cfg_h;
    logic                    geom_wr;

    assign cfg_sel = cfg_idx_t'(cfg_index);
    assign sg      = signed_reg & SIGN_VALID;
    assign geom_wr = cfg_we && (cfg_sel == CFG_WIDTH || cfg_sel == CFG_HEIGHT);

    // Out-of-range geometry is clamped once, at write time.
    always_comb begin
        iw = cfg_wdata[IMG_W_BITS-1:0];
        ih = cfg_wdata[IMG_H_BITS-1:0];
        if (iw == '0) begin
            cfg_w = CW'(1);
        end else if (32'(iw) > 32'(MAX_WIDTH)) begin
            cfg_w = CW'(MAX_WIDTH);
        end else begin
            cfg_w = CW'(iw);
        end
        cfg_h = (ih == '0) ? IMG_H_BITS'(1) : ih;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dilate_reg <= 1'b0;
            cross_reg  <= 1'b0;
            signed_reg <= 1'b0;
            eff_w_reg  <= CW'(W_RST);
            wm1_reg    <= CW'(W_RST - 1);
            eff_h_reg  <= IMG_H_BITS'(HEIGHT_RST);
            hm1_reg    <= IMG_H_BITS'(HEIGHT_RST - 1);
        end else if (cfg_we) begin
            unique case (cfg_sel)
                CFG_DILATE: dilate_reg <= cfg_wdata[0];
                CFG_CROSS:  cross_reg  <= cfg_wdata[0];
                CFG_SIGNED: signed_reg <= cfg_wdata[0];
                CFG_WIDTH: begin
                    eff_w_reg <= cfg_w;
                    wm1_reg   <= cfg_w - CW'(1);
                end
                CFG_HEIGHT: begin
                    eff_h_reg <= cfg_h;
                    hm1_reg   <= cfg_h - IMG_H_BITS'(1);
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: position tracking and line memory read issue
    // ------------------------------------------------------------------
    logic [IO_BITS-1:0]      in_all [3];
    logic [CW-1:0]           col_reg;
    logic [IMG_H_BITS-1:0]   row_reg;
    logic [CW-1:0]           drain_reg;
    logic                    frame_done;
    logic [IMG_H_BITS-1:0]   row_cur;
    logic [CW-1:0]           col_cur;
    logic [CW-1:0]           col_inc;
    logic                    row_wrap;
    logic                    drain_ok;
    logic [CW-1:0]           drain_inc;
    logic [AW-1:0]           rd_addr;
    logic                    accept;

    assign in_all[0] = s_in_ch0;
    assign in_all[1] = s_in_ch1;
    assign in_all[2] = s_in_ch2;
    assign accept    = s_valid && s_ready;

    always_comb begin
        // a pixel after a completed frame starts the next frame
        frame_done = (row_reg >= eff_h_reg);
        row_cur    = frame_done ? '0 : row_reg;
        col_cur    = frame_done ? '0 : col_reg;
        if (col_cur >= eff_w_reg) begin
            col_cur = '0;
        end
        col_inc    = col_cur + CW'(1);
        row_wrap   = (col_inc >= eff_w_reg);
        drain_ok   = frame_done && (drain_reg < eff_w_reg);
        drain_inc  = drain_reg + CW'(1);
        // drain fetches the right-hand neighbor column, clamped at the edge
        if (s_action == ACT_DRAIN) begin
            rd_addr = (drain_inc < eff_w_reg) ? drain_inc[AW-1:0] : drain_reg[AW-1:0];
        end else begin
            rd_addr = col_cur[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || geom_wr) begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end else if (accept) begin
            if (s_action == ACT_DRAIN) begin
                if (drain_ok) begin
                    if (drain_inc >= eff_w_reg) begin
                        col_reg   <= '0;
                        row_reg   <= '0;
                        drain_reg <= '0;
                    end else begin
                        drain_reg <= drain_inc;
                    end
                end
            end else begin
                drain_reg <= frame_done ? '0 : drain_reg;
                if (row_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_cur + IMG_H_BITS'(1);
                end else begin
                    col_reg <= col_inc;
                    row_reg <= row_cur;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B registers
    // ------------------------------------------------------------------
    logic                    b_valid_reg;
    logic                    b_pix_reg;
    logic                    b_drn_reg;
    logic                    b_row0_reg;
    logic                    b_e1_reg;
    logic                    b_e2_reg;
    logic                    b_lastrow_reg;
    logic                    b_eof_reg;
    logic [AW-1:0]           b_x_reg;
    logic [SW-1:0]           b_p_reg [CHANNELS];
    logic                    b_adv;
    logic                    c_free;

    assign b_adv   = b_valid_reg && c_free;
    assign s_ready = !b_valid_reg || c_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_ready) begin
            b_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_pix_reg     <= (s_action == ACT_PIXEL);
            b_drn_reg     <= (s_action == ACT_DRAIN) && drain_ok;
            b_row0_reg    <= (row_cur == '0);
            b_e1_reg      <= (row_cur != '0) && (col_cur != '0);
            b_e2_reg      <= (row_cur != '0) && (col_cur == wm1_reg);
            b_lastrow_reg <= (row_cur == hm1_reg) && (col_cur == '0);
            b_eof_reg     <= (drain_reg == wm1_reg);
            b_x_reg       <= col_cur[AW-1:0];
            for (int c = 0; c < CHANNELS; c++) begin
                b_p_reg[c] <= in_all[c][SW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memory: per column the two rows above the incoming one.
    // A write from stage B and a read from stage A can hit the same
    // column in one cycle (width one, or the first drain read at width
    // two); the written word is forwarded.
    // ------------------------------------------------------------------
    logic [MW-1:0]           line_mem [MAX_WIDTH];
    logic [MW-1:0]           mem_q_reg;
    logic                    fwd_hit_reg;
    logic [MW-1:0]           fwd_data_reg;
    logic                    mem_we;
    logic [MW-1:0]           mem_wdata;
    logic [MW-1:0]           rd_word;

    assign mem_we  = b_adv && b_pix_reg;
    assign rd_word = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[b_x_reg] <= mem_wdata;
        end
        if (accept) begin
            mem_q_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_hit_reg  <= mem_we && (b_x_reg == rd_addr);
            fwd_data_reg <= mem_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: column assembly, window shift, operand selection.
    // Windows keep raw samples so a mode change between frames or rows
    // applies to everything emitted afterwards.
    // ------------------------------------------------------------------
    logic [SW-1:0]           wa_u_reg [CHANNELS];
    logic [SW-1:0]           wa_m_reg [CHANNELS];
    logic [SW-1:0]           wa_l_reg [CHANNELS];
    logic [SW-1:0]           wb_u_reg [CHANNELS];
    logic [SW-1:0]           wb_m_reg [CHANNELS];
    logic [SW-1:0]           wb_l_reg [CHANNELS];
    logic [SW-1:0]           dl_u_reg [CHANNELS];
    logic [SW-1:0]           dl_m_reg [CHANNELS];
    logic [SW-1:0]           dc_u_reg [CHANNELS];
    logic [SW-1:0]           dc_m_reg [CHANNELS];

    logic [SW-1:0]           rd_u  [CHANNELS];
    logic [SW-1:0]           rd_m  [CHANNELS];
    logic [SW-1:0]           pu    [CHANNELS];
    logic [SW-1:0]           pm    [CHANNELS];
    logic [SW-1:0]           n0_u  [CHANNELS];
    logic [SW-1:0]           n0_m  [CHANNELS];
    logic [SW-1:0]           n0_l  [CHANNELS];
    logic [SW-1:0]           n1_u  [CHANNELS];
    logic [SW-1:0]           n1_m  [CHANNELS];
    logic [SW-1:0]           n1_l  [CHANNELS];
    logic [SW-1:0]           op_nx [2][CHANNELS][3];
    logic [1:0]              b_cnt;

    always_comb begin
        logic [SW-1:0] v_n0;
        logic [SW-1:0] v_n1;
        logic [SW-1:0] v_r;
        logic [SW-1:0] s_n0;
        logic [SW-1:0] s_n1;
        logic [SW-1:0] s_r;
        logic [SW-1:0] v_dl;
        logic [SW-1:0] v_dc;
        logic [SW-1:0] v_rt;
        logic [SW-1:0] s_dl;
        logic [SW-1:0] s_rt;
        mem_wdata = '0;
        b_cnt     = 2'd0;
        for (int c = 0; c < CHANNELS; c++) begin
            rd_u[c] = rd_word[HW + c*SW +: SW];
            rd_m[c] = rd_word[c*SW +: SW];
            // top edge replication
            pu[c]   = b_row0_reg ? b_p_reg[c] : rd_u[c];
            pm[c]   = b_row0_reg ? b_p_reg[c] : rd_m[c];
            mem_wdata[HW + c*SW +: SW] = pm[c];
            mem_wdata[c*SW +: SW]      = b_p_reg[c];

            // left edge replication at column zero
            n0_u[c] = (b_x_reg == '0) ? pu[c]      : wa_u_reg[c];
            n0_m[c] = (b_x_reg == '0) ? pm[c]      : wa_m_reg[c];
            n0_l[c] = (b_x_reg == '0) ? b_p_reg[c] : wa_l_reg[c];
            n1_u[c] = (b_x_reg == '0) ? pu[c]      : wb_u_reg[c];
            n1_m[c] = (b_x_reg == '0) ? pm[c]      : wb_m_reg[c];
            n1_l[c] = (b_x_reg == '0) ? b_p_reg[c] : wb_l_reg[c];

            v_n0 = pick2(pick2(n0_u[c], n0_m[c], dilate_reg, sg), n0_l[c], dilate_reg, sg);
            v_n1 = pick2(pick2(n1_u[c], n1_m[c], dilate_reg, sg), n1_l[c], dilate_reg, sg);
            v_r  = pick2(pick2(pu[c], pm[c], dilate_reg, sg), b_p_reg[c], dilate_reg, sg);
            // cross uses only the middle sample of the side columns
            s_n0 = cross_reg ? n0_m[c] : v_n0;
            s_n1 = cross_reg ? n1_m[c] : v_n1;
            s_r  = cross_reg ? pm[c]   : v_r;

            // drain columns repeat the bottom row below itself
            v_dl = pick2(dl_u_reg[c], dl_m_reg[c], dilate_reg, sg);
            v_dc = pick2(dc_u_reg[c], dc_m_reg[c], dilate_reg, sg);
            v_rt = pick2(rd_u[c], rd_m[c], dilate_reg, sg);
            s_dl = cross_reg ? dl_m_reg[c] : v_dl;
            s_rt = cross_reg ? rd_m[c]     : v_rt;

            if (b_drn_reg) begin
                op_nx[0][c][0] = s_dl;
                op_nx[0][c][1] = v_dc;
                op_nx[0][c][2] = s_rt;
            end else if (b_e1_reg) begin
                op_nx[0][c][0] = s_n0;
                op_nx[0][c][1] = v_n1;
                op_nx[0][c][2] = s_r;
            end else begin
                op_nx[0][c][0] = s_n1;
                op_nx[0][c][1] = v_r;
                op_nx[0][c][2] = s_r;
            end
            // second result: the rightmost column of the row
            op_nx[1][c][0] = s_n1;
            op_nx[1][c][1] = v_r;
            op_nx[1][c][2] = s_r;
        end
        if (b_drn_reg) begin
            b_cnt = 2'd1;
        end else if (b_pix_reg) begin
            b_cnt = {1'b0, b_e1_reg} + {1'b0, b_e2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && b_pix_reg) begin
            for (int c = 0; c < CHANNELS; c++) begin
                wa_u_reg[c] <= n1_u[c];
                wa_m_reg[c] <= n1_m[c];
                wa_l_reg[c] <= n1_l[c];
                wb_u_reg[c] <= pu[c];
                wb_m_reg[c] <= pm[c];
                wb_l_reg[c] <= b_p_reg[c];
            end
        end
        if (b_adv && b_pix_reg && b_lastrow_reg) begin
            // first column of the bottom row seeds the drain window
            for (int c = 0; c < CHANNELS; c++) begin
                dl_u_reg[c] <= pm[c];
                dl_m_reg[c] <= b_p_reg[c];
                dc_u_reg[c] <= pm[c];
                dc_m_reg[c] <= b_p_reg[c];
            end
        end else if (b_adv && b_drn_reg) begin
            for (int c = 0; c < CHANNELS; c++) begin
                dl_u_reg[c] <= dc_u_reg[c];
                dl_m_reg[c] <= dc_m_reg[c];
                dc_u_reg[c] <= rd_u[c];
                dc_m_reg[c] <= rd_m[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: up to two pending results, final 3-way selection into the
    // output register.
    // ------------------------------------------------------------------
    logic [SW-1:0]           c_op_reg [2][CHANNELS][3];
    logic [1:0]              c_cnt_reg;
    logic                    c_eof_reg;
    logic                    out_load;
    logic [SW-1:0]           out_v [3];

    logic                    m_valid_reg;
    logic [IO_BITS-1:0]      m_ch_reg [3];
    logic                    m_last_reg;
    logic                    m_eof_reg;

    assign out_load = (c_cnt_reg != 2'd0) && (!m_valid_reg || m_ready);
    assign c_free   = (c_cnt_reg == 2'd0) || ((c_cnt_reg == 2'd1) && out_load);

    // channels at or beyond CHANNELS read as zero
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            out_v[c] = '0;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            out_v[c] = pick2(pick2(c_op_reg[0][c][0], c_op_reg[0][c][1], dilate_reg, sg),
                             c_op_reg[0][c][2], dilate_reg, sg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_cnt_reg <= 2'd0;
        end else if (b_adv) begin
            c_cnt_reg <= b_cnt;
        end else if (out_load) begin
            c_cnt_reg <= c_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            c_op_reg  <= op_nx;
            c_eof_reg <= b_drn_reg && b_eof_reg;
        end else if (out_load) begin
            c_op_reg[0] <= c_op_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int c = 0; c < 3; c++) begin
                m_ch_reg[c] <= IO_BITS'(out_v[c]);
            end
            m_last_reg <= (c_cnt_reg == 2'd1);
            m_eof_reg  <= c_eof_reg && (c_cnt_reg == 2'd1);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_ch0      = m_ch_reg[0];
    assign m_out_ch1      = m_ch_reg[1];
    assign m_out_ch2      = m_ch_reg[2];
    assign m_last_in_run  = m_last_reg;
    assign m_end_of_frame = m_eof_reg;

endmodule

// File: tb/tb_morph_erode_dilate_3x3.sv
// Testbench for the 3x3 erode/dilate pixel stream filter.
// Sends pixel and drain requests under random valid/ready gaps, predicts every filtered
// pixel in a scoreboard class and checks each result. Depends on morph_pkg and the RTL.
module tb_morph_erode_dilate_3x3;
    import morph_pkg::*;

    localparam int          MAXW          = MAX_WIDTH_DEF;
    localparam int          RANDOM_ITEMS  = 600;
    localparam int          IDLE_PCT      = 11;
    localparam int          HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int          SETTLE_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    localparam logic [IO_BITS-1:0] SIGN_BIT = {1'b1, {(IO_BITS-1){1'b0}}};

    typedef logic [2:0][IO_BITS-1:0]      pix_t;     // [channel]
    typedef logic [2:0][2:0][IO_BITS-1:0] column_t;  // [above/center/below][channel]

    typedef struct packed {
        logic [IO_BITS-1:0] ch0;
        logic [IO_BITS-1:0] ch1;
        logic [IO_BITS-1:0] ch2;
        logic               last_in_run;
        logic               end_of_frame;
    } filtered_px_t;

    // Scoreboard: keeps its own copy of the line history and the 3-column window,
    // and queues the filtered pixels each accepted request should produce.
    class erode_dilate_scoreboard;
        bit                    dilate_on;
        bit                    cross_nbhd;
        bit                    signed_cmp;
        logic [IMG_W_BITS-1:0] width_reg;
        logic [IMG_H_BITS-1:0] height_reg;
        pix_t                  row_above  [MAXW];   // only read after written in a frame
        pix_t                  row_center [MAXW];
        column_t               window     [3];      // left, center, right column
        int unsigned           col_pos;
        int unsigned           row_pos;
        int unsigned           drain_pos;
        filtered_px_t          pending_pixels [$];
        int unsigned           pixel_reqs;
        int unsigned           drain_reqs;
        int unsigned           results_seen;
        int unsigned           failures;

        function new();
            dilate_on  = 1'b0;
            cross_nbhd = 1'b0;
            signed_cmp = 1'b0;
            width_reg  = IMG_W_BITS'(WIDTH_RST);
            height_reg = IMG_H_BITS'(HEIGHT_RST);
            foreach (window[i]) window[i] = '0;
            restart_frame();
        endfunction

        function void restart_frame();
            col_pos   = 0;
            row_pos   = 0;
            drain_pos = 0;
        endfunction

        function void apply_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_DILATE: dilate_on  = val[0];
                CFG_CROSS:  cross_nbhd = val[0];
                CFG_SIGNED: signed_cmp = val[0];
                CFG_WIDTH: begin
                    width_reg = val[IMG_W_BITS-1:0];
                    restart_frame();
                end
                CFG_HEIGHT: begin
                    height_reg = val[IMG_H_BITS-1:0];
                    restart_frame();
                end
                default: ;
            endcase
        endfunction

        // min for erode, max for dilate; signed mode flips the sign bit for ordering
        function logic [IO_BITS-1:0] rank_pick(logic [IO_BITS-1:0] a, logic [IO_BITS-1:0] b);
            logic [IO_BITS-1:0] ka, kb;
            ka = signed_cmp ? (a ^ SIGN_BIT) : a;
            kb = signed_cmp ? (b ^ SIGN_BIT) : b;
            if (dilate_on) return (ka >= kb) ? a : b;
            return (ka <= kb) ? a : b;
        endfunction

        function void add_expected(column_t l, column_t c, column_t r, bit eof, bit last);
            pix_t         v;
            filtered_px_t e;
            int           ch;
            for (ch = 0; ch < 3; ch++) begin
                v[ch] = c[1][ch];
                v[ch] = rank_pick(v[ch], c[0][ch]);
                v[ch] = rank_pick(v[ch], c[2][ch]);
                v[ch] = rank_pick(v[ch], l[1][ch]);
                v[ch] = rank_pick(v[ch], r[1][ch]);
                if (!cross_nbhd) begin
                    v[ch] = rank_pick(v[ch], l[0][ch]);
                    v[ch] = rank_pick(v[ch], l[2][ch]);
                    v[ch] = rank_pick(v[ch], r[0][ch]);
                    v[ch] = rank_pick(v[ch], r[2][ch]);
                end
            end
            e.ch0          = v[0];
            e.ch1          = v[1];
            e.ch2          = v[2];
            e.last_in_run  = last;
            e.end_of_frame = eof;
            pending_pixels.push_back(e);
        endfunction

        // bottom row: the row below replicates the center row
        function column_t drain_column(int unsigned x);
            column_t c;
            c[0] = row_above[x];
            c[1] = row_center[x];
            c[2] = row_center[x];
            return c;
        endfunction

        function void note_request(logic act, pix_t p);
            int unsigned w, h, x;
            column_t     col;
            w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
            h = (height_reg == 0) ? 1 : height_reg;
            if (act == ACT_DRAIN) begin
                drain_reqs++;
                // ignored until the frame is complete
                if (row_pos < h || drain_pos >= w) return;
                x = drain_pos;
                add_expected(drain_column((x > 0) ? x - 1 : x), drain_column(x),
                             drain_column((x + 1 < w) ? x + 1 : x), x == w - 1, 1'b1);
                drain_pos++;
                if (drain_pos >= w) restart_frame();
                return;
            end
            pixel_reqs++;
            // a pixel after a complete, undrained frame starts a new one
            if (row_pos >= h) restart_frame();
            if (col_pos >= w) col_pos = 0;
            x = col_pos;
            col[2] = p;
            col[1] = (row_pos == 0) ? p : row_center[x];   // top edge replication
            col[0] = (row_pos == 0) ? p : row_above[x];
            row_above[x]  = col[1];
            row_center[x] = p;
            if (x == 0) begin
                window[0] = col;
                window[1] = col;
                window[2] = col;
            end else begin
                window[0] = window[1];
                window[1] = window[2];
                window[2] = col;
            end
            if (row_pos >= 1) begin
                if (x >= 1) add_expected(window[0], window[1], window[2], 1'b0, x != w - 1);
                // rightmost column replicates itself
                if (x == w - 1) add_expected(window[1], window[2], window[2], 1'b0, 1'b1);
            end
            col_pos = x + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        endfunction

        function void check_result(filtered_px_t got);
            filtered_px_t e;
            results_seen++;
            if (pending_pixels.size() == 0) begin
                $error("result with no request pending: ch0 %h ch1 %h ch2 %h",
                       got.ch0, got.ch1, got.ch2);
                failures++;
                return;
            end
            e = pending_pixels.pop_front();
            if (got.ch0 !== e.ch0) begin
                $error("out_ch0: expected %h, got %h", e.ch0, got.ch0);
                failures++;
            end
            if (got.ch1 !== e.ch1) begin
                $error("out_ch1: expected %h, got %h", e.ch1, got.ch1);
                failures++;
            end
            if (got.ch2 !== e.ch2) begin
                $error("out_ch2: expected %h, got %h", e.ch2, got.ch2);
                failures++;
            end
            if (got.last_in_run !== e.last_in_run) begin
                $error("last_in_run: expected %b, got %b", e.last_in_run, got.last_in_run);
                failures++;
            end
            if (got.end_of_frame !== e.end_of_frame) begin
                $error("end_of_frame: expected %b, got %b", e.end_of_frame, got.end_of_frame);
                failures++;
            end
        endfunction
    endclass

    // DUT ports, all inputs known from time zero
    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    cfg_idx_t                 cfg_index = CFG_DILATE;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic                     s_action  = ACT_PIXEL;
    logic [IO_BITS-1:0]       s_in_ch0  = '0;
    logic [IO_BITS-1:0]       s_in_ch1  = '0;
    logic [IO_BITS-1:0]       s_in_ch2  = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic [IO_BITS-1:0]       m_out_ch0;
    logic [IO_BITS-1:0]       m_out_ch1;
    logic [IO_BITS-1:0]       m_out_ch2;
    logic                     m_last_in_run;
    logic                     m_end_of_frame;

    erode_dilate_scoreboard sb;

    // traffic shaping, written by the main process only
    int unsigned src_idle_pct  = IDLE_PCT;
    int unsigned sink_idle_pct = IDLE_PCT;
    int unsigned hold_asks     = 0;
    int unsigned item_count    = 0;
    int unsigned setups        = 0;

    // hold state owned by the receiver process, cycle count by the watchdog
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    morph_erode_dilate_3x3 dut (.*);

    always #4 aclk = ~aclk;

    // Monitor: both channels sampled at the rising edge. Results are checked before the
    // same-edge request is noted; a request's results can't show up on its own edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result({m_out_ch0, m_out_ch1, m_out_ch2, m_last_in_run,
                                 m_end_of_frame});
            if (s_valid && s_ready)
                sb.note_request(s_action, {s_in_ch2, s_in_ch1, s_in_ch0});
        end
    end

    // Receiver: random ready, plus a counted hold-off when the main flow asks for one.
    always @(negedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Samples lean toward the ordering extremes so min/max picks hit the sign boundary.
    function automatic pix_t rand_pixel();
        pix_t p;
        int   ch;
        for (ch = 0; ch < 3; ch++) begin
            case ($urandom_range(7))
                0:       p[ch] = 16'h0000;
                1:       p[ch] = 16'hFFFF;
                2:       p[ch] = 16'h8000;
                3:       p[ch] = 16'h7FFF;
                default: p[ch] = IO_BITS'($urandom());
            endcase
        end
        return p;
    endfunction

    // Register write; only called while the filter is idle. Returns on a falling edge.
    task automatic program_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        sb.apply_reg(idx, val);
    endtask

    // One request: optional random gap, then hold valid and payload until taken.
    // Called and returns on a falling edge; valid stays high into the next request.
    task automatic send_request(input logic act, input pix_t p);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_in_ch0 <= p[0];
        s_in_ch1 <= p[1];
        s_in_ch2 <= p[2];
        do begin
            @(posedge aclk);
            taken = s_ready;
            @(negedge aclk);
        end while (!taken);
    endtask

    // Pixels then drain ticks; noise adds stray drain ticks ahead of some pixels.
    task automatic send_stream(input int unsigned n_pix, input int unsigned n_drain,
                               input bit noise);
        for (int unsigned i = 0; i < n_pix; i++) begin
            if (noise && $urandom_range(19) == 0)
                send_request(ACT_DRAIN, rand_pixel());
            send_request(ACT_PIXEL, rand_pixel());
            item_count++;
        end
        repeat (n_drain) begin
            send_request(ACT_DRAIN, rand_pixel());
            item_count++;
        end
    endtask

    // Sender pause: everything predicted has come back, then the pipeline empties.
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int unsigned w, h, ew, eh;
        sb = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Small 3x2 frame: erode, square, unsigned. Pixels written {ch2, ch1, ch0}.
        program_reg(CFG_DILATE, 16'h0000);
        program_reg(CFG_CROSS,  16'h0000);
        program_reg(CFG_SIGNED, 16'h0000);
        program_reg(CFG_WIDTH,  16'd3);
        program_reg(CFG_HEIGHT, 16'd2);
        setups++;
        send_request(ACT_DRAIN, '0);                              // early drain, ignored
        send_request(ACT_PIXEL, {16'h8000, 16'hFFFF, 16'h0000});  // top row: no results
        send_request(ACT_PIXEL, {16'h7FFF, 16'h0000, 16'hFFFF});
        send_request(ACT_PIXEL, {16'h0001, 16'h7FFF, 16'h8000});
        send_request(ACT_PIXEL, {16'hFFFE, 16'h8000, 16'h7FFF});
        send_request(ACT_PIXEL, {16'h0000, 16'hFFFE, 16'h0001});
        send_request(ACT_PIXEL, {16'hFFFF, 16'h0001, 16'hFFFE});  // end of row: two results
        repeat (3) send_request(ACT_DRAIN, '1);                   // bottom row, end of frame
        send_request(ACT_DRAIN, '1);                              // counters cleared: ignored
        settle();

        // Geometry zero counts as one; dilate, cross, signed
        program_reg(CFG_DILATE, 16'hFFFF);
        program_reg(CFG_CROSS,  16'hFFFF);
        program_reg(CFG_SIGNED, 16'hFFFF);
        program_reg(CFG_WIDTH,  16'h0000);
        program_reg(CFG_HEIGHT, 16'h0000);
        setups++;
        send_request(ACT_PIXEL, {16'h8000, 16'h7FFF, 16'h0000});  // frame complete
        send_request(ACT_PIXEL, {16'h7FFF, 16'h8000, 16'hFFFF});  // undrained: new frame
        send_request(ACT_DRAIN, '0);
        settle();

        // Single column, two rows: the column is its own neighbor
        program_reg(CFG_HEIGHT, 16'd2);
        setups++;
        send_request(ACT_PIXEL, {16'hFFFF, 16'h0000, 16'h8000});
        send_request(ACT_PIXEL, {16'h0000, 16'hFFFF, 16'h7FFF});
        send_request(ACT_DRAIN, '0);
        settle();

        // Largest geometry, abandoned partway by a height write; an early drain is ignored
        program_reg(CFG_WIDTH,  16'hFFFF);
        program_reg(CFG_HEIGHT, 16'hFFFF);
        setups++;
        send_stream(3, 0, 1'b0);
        settle();
        program_reg(CFG_HEIGHT, 16'h0001);
        setups++;
        send_stream(3, 1, 1'b0);
        settle();

        // Random setups. Mostly complete frames; some undrained, part-drained or cut short.
        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            settle();
            // one phase with a long receiver hold-off, one with no gaps on either side
            if (setups == 5) hold_asks++;
            src_idle_pct  = (setups == 6) ? 0 : IDLE_PCT;
            sink_idle_pct = (setups == 6) ? 0 : IDLE_PCT;
            case ($urandom_range(7))
                0:       w = 0;
                1:       w = 1;
                2:       w = 2;
                default: w = $urandom_range(3, 12);
            endcase
            h  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
            if (setups == 5 || setups == 6) begin
                w = $urandom_range(16, 24);
                h = 4;
            end
            ew = (w == 0) ? 1 : w;
            eh = (h == 0) ? 1 : h;
            program_reg(CFG_DILATE, CFG_DATA_BITS'($urandom()));
            program_reg(CFG_CROSS,  CFG_DATA_BITS'($urandom()));
            program_reg(CFG_SIGNED, CFG_DATA_BITS'($urandom()));
            program_reg(CFG_WIDTH,  {4'($urandom()), 12'(w)});
            program_reg(CFG_HEIGHT, 16'(h));
            setups++;
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(9))
                    7:       send_stream(ew * eh, 0, 1'b1);
                    8:       send_stream(ew * eh, $urandom_range(1, ew), 1'b1);
                    9:       send_stream($urandom_range(1, ew * eh), $urandom_range(0, 2), 1'b1);
                    default: send_stream(ew * eh, ew, 1'b1);
                endcase
            end
        end

        src_idle_pct = IDLE_PCT;
        settle();
        $display("Covered %0d pixel and %0d drain requests over %0d register setups,",
                 sb.pixel_reqs, sb.drain_reqs, setups);
        $display("with %0d filtered pixels checked and %0d mismatches.",
                 sb.results_seen, sb.failures);
        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
